// File: rtl/feedback_delay_line_mix_defines.svh
// Assertion shorthands shared by the checkers of this block.
`ifndef FEEDBACK_DELAY_LINE_MIX_DEFINES_SVH
`define FEEDBACK_DELAY_LINE_MIX_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FDLM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FDLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fdlm_pkg.sv
package fdlm_pkg;

	// store depth must be a power of two: read address wraps by truncation
	localparam int DELAY_DEPTH = 131072;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int SAMPLE_W    = 24;
	localparam int DELAY_W     = 17;
	localparam int GAIN_W      = 16;
	localparam int MIX_W       = 16;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 2;

	localparam int Q15_ONE     = 32768;
	localparam int MIX_RESET   = 16384;
	localparam int Q_FRAC      = 15;
	localparam int RND_BIAS    = 16384;

	localparam int FB_PROD_W   = GAIN_W + SAMPLE_W;
	localparam int MIX_PROD_W  = MIX_W + 1 + SAMPLE_W;
	localparam int ACC_W       = MIX_PROD_W + 2;

	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	localparam acc_t SAT_HI = acc_t'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
	localparam acc_t SAT_LO = -SAT_HI - acc_t'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH  = 2'd0,
		REG_FEEDBACK_GAIN = 2'd1,
		REG_MIX_LEVEL     = 2'd2,
		REG_BYPASS        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic    en;
		addr_t   addr;
		sample_t data;
	} wr_req_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} rd_req_t;

	// floor((v + half) / 2^15)
	function automatic acc_t round_q15(input acc_t v);
		return (v + acc_t'(RND_BIAS)) >>> Q_FRAC;
	endfunction

	function automatic sample_t sat_sample(input acc_t v);
		priority if (v > SAT_HI) begin
			return SAT_HI[SAMPLE_W-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[SAMPLE_W-1:0];
		end else begin
			return v[SAMPLE_W-1:0];
		end
	endfunction

endpackage

// File: rtl/fdlm_store.sv
module fdlm_store (
	input  logic              clk,
	input  logic              arst_n,
	input  fdlm_pkg::wr_req_t wr,
	input  fdlm_pkg::rd_req_t rd,
	output fdlm_pkg::sample_t rdata,
	output logic              busy
);

	fdlm_pkg::sample_t mem [fdlm_pkg::DELAY_DEPTH];
	fdlm_pkg::sample_t rdata_q;
	fdlm_pkg::addr_t   clr_q;
	logic              busy_q;

	// zeroing sweep after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + fdlm_pkg::addr_t'(1);
			if (clr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// File: rtl/feedback_delay_line_mix.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------
// input     | in        | in_valid / in_stall  | sample_in  [23:0] s
// output    | out       | out_valid / out_stall| sample_out [23:0] s
// config    | in        | cfg_we               | cfg_index, cfg_data
//
// One sample per cycle while no stall is held; a taken request passes stage 1, stage 2 and the output register.
// The rate is set by the feedback loop: forward select, multiply, round and saturate.
// After reset the store is zeroed, all 131072 entries, with in_stall held high.
// out_stall backs up to in_stall in the same cycle; nothing is dropped.
module feedback_delay_line_mix (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  fdlm_pkg::sample_t                    sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output fdlm_pkg::sample_t                    sample_out,
	input  logic                                 cfg_we,
	input  logic [fdlm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fdlm_pkg::CFG_W-1:0]           cfg_data
);

	// configuration
	logic [fdlm_pkg::DELAY_W-1:0]       delay_q;
	logic signed [fdlm_pkg::GAIN_W-1:0] fb_q;
	logic [fdlm_pkg::MIX_W-1:0]         mix_q;
	logic [fdlm_pkg::MIX_W-1:0]         dry_q;
	logic                               bypass_q;
	logic [fdlm_pkg::MIX_W-1:0]         mix_in;

	fdlm_pkg::addr_t wp_q;

	logic v_s1, v_s2, v_s3;
	fdlm_pkg::sample_t x_s1, x_s2;
	fdlm_pkg::addr_t   rd_s1, wp_s1, wp_s2, wp_s3;
	logic              dz_s1;
	logic signed [fdlm_pkg::FB_PROD_W-1:0]  pfb_s2;
	logic signed [fdlm_pkg::MIX_PROD_W-1:0] pwet_s2, pdry_s2;
	fdlm_pkg::sample_t stored_s3, out_s3;

	logic              adv, accept, busy, hit_s2, hit_s3;
	fdlm_pkg::addr_t   rd_c;
	fdlm_pkg::sample_t rdata, y_c, stored_c, mix_c, out_c;
	logic signed [fdlm_pkg::FB_PROD_W-1:0]  pfb_c;
	logic signed [fdlm_pkg::MIX_PROD_W-1:0] pwet_c, pdry_c;
	fdlm_pkg::wr_req_t wr;
	fdlm_pkg::rd_req_t rd;

	// mix above one clamps to one
	assign mix_in = (cfg_data[fdlm_pkg::MIX_W-1:0] > fdlm_pkg::MIX_W'(fdlm_pkg::Q15_ONE))
		? fdlm_pkg::MIX_W'(fdlm_pkg::Q15_ONE) : cfg_data[fdlm_pkg::MIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= '0;
			fb_q     <= '0;
			mix_q    <= fdlm_pkg::MIX_W'(fdlm_pkg::MIX_RESET);
			dry_q    <= fdlm_pkg::MIX_W'(fdlm_pkg::Q15_ONE - fdlm_pkg::MIX_RESET);
			bypass_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (fdlm_pkg::reg_idx_t'(cfg_index))
				fdlm_pkg::REG_DELAY_LENGTH: begin
					delay_q <= cfg_data[fdlm_pkg::DELAY_W-1:0];
				end
				fdlm_pkg::REG_FEEDBACK_GAIN: begin
					fb_q <= signed'(cfg_data[fdlm_pkg::GAIN_W-1:0]);
				end
				fdlm_pkg::REG_MIX_LEVEL: begin
					mix_q <= mix_in;
					dry_q <= fdlm_pkg::MIX_W'(fdlm_pkg::Q15_ONE) - mix_in;
				end
				fdlm_pkg::REG_BYPASS: begin
					bypass_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline moves as a whole whenever the output register can take a result
	assign adv      = !v_s3 || !out_stall;
	assign in_stall = busy || !adv;
	assign accept   = in_valid && !in_stall;
	assign rd_c     = wp_q - fdlm_pkg::addr_t'(delay_q);

	assign rd.en   = accept;
	assign rd.addr = rd_c;

	fdlm_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rdata  (rdata),
		.busy   (busy)
	);

	// stage 1: pick the delayed value; the two samples ahead are not in the store yet
	assign hit_s2 = v_s2 && (wp_s2 == rd_s1);
	assign hit_s3 = v_s3 && (wp_s3 == rd_s1);

	always_comb begin
		priority if (dz_s1) begin
			y_c = x_s1;
		end else if (hit_s2) begin
			y_c = stored_c;
		end else if (hit_s3) begin
			y_c = stored_s3;
		end else begin
			y_c = rdata;
		end
	end

	assign pfb_c  = fdlm_pkg::FB_PROD_W'(fb_q) * fdlm_pkg::FB_PROD_W'(y_c);
	assign pwet_c = fdlm_pkg::MIX_PROD_W'(signed'({1'b0, mix_q}))
		* fdlm_pkg::MIX_PROD_W'(y_c);
	assign pdry_c = fdlm_pkg::MIX_PROD_W'(signed'({1'b0, dry_q}))
		* fdlm_pkg::MIX_PROD_W'(x_s1);

	// stage 2: round, sum, saturate
	assign stored_c = fdlm_pkg::sat_sample(fdlm_pkg::acc_t'(x_s2)
		+ fdlm_pkg::round_q15(fdlm_pkg::acc_t'(pfb_s2)));
	assign mix_c    = fdlm_pkg::sat_sample(fdlm_pkg::round_q15(
		fdlm_pkg::acc_t'(pwet_s2) + fdlm_pkg::acc_t'(pdry_s2)));
	assign out_c    = bypass_q ? x_s2 : mix_c;

	assign wr.en   = adv && v_s2 && !bypass_q;
	assign wr.addr = wp_s2;
	assign wr.data = stored_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			wp_q <= '0;
		end else begin
			if (adv) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (accept && !bypass_q) begin
				wp_q <= wp_q + fdlm_pkg::addr_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= sample_in;
			rd_s1 <= rd_c;
			wp_s1 <= wp_q;
			dz_s1 <= (delay_q == '0);
		end
		if (adv) begin
			x_s2      <= x_s1;
			wp_s2     <= wp_s1;
			pfb_s2    <= pfb_c;
			pwet_s2   <= pwet_c;
			pdry_s2   <= pdry_c;
			wp_s3     <= wp_s2;
			stored_s3 <= stored_c;
			out_s3    <= out_c;
		end
	end

	assign out_valid  = v_s3;
	assign sample_out = out_s3;

endmodule

// File: rtl/fdlm_checker.sv
`include "feedback_delay_line_mix_defines.svh"

module fdlm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input fdlm_pkg::sample_t sample_out
);

	logic [2:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// requests taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	`FDLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out), "output changed while stalled")
	`FDLM_ASSERT_NOW(a_clear_stall, $rose(arst_n), in_stall, "input open before store cleared")
	`FDLM_ASSERT_NOW(a_no_phantom, out_valid, pend_q != 3'd0, "result without a pending request")
	`FDLM_ASSERT_NOW(a_backpressure, out_valid && out_stall, in_stall, "input taken with output blocked")

endmodule

bind feedback_delay_line_mix fdlm_checker u_fdlm_checker (.*);
